[sv/sbpm_pkg.sv]
// Package for the spectral bin phase modifier: widths, register indexes,
// CORDIC constants and small shared types. Used by the CORDIC modules and the top level in sv/.
package sbpm_pkg;

    localparam int SampleWidth = 32;
    localparam int Guard       = 60 - SampleWidth;
    localparam int AccWidth    = 64;
    localparam int AngWidth    = 25;
    localparam int CordicSteps = 21;
    localparam int EdgeWidth   = 3;
    localparam int HalfBins    = 512;
    localparam int BinWidth    = 10;
    localparam int KWidth      = 5;
    localparam int SideWidth   = 32;

    localparam logic [1:0] RegPhaseMode = 2'd0;
    localparam logic [1:0] RegBandEn    = 2'd1;
    localparam logic [1:0] RegBandLow   = 2'd2;
    localparam logic [1:0] RegBandHigh  = 2'd3;

    localparam logic signed [AngWidth-1:0] AngHalfPi = 25'sd2097152;
    localparam logic [31:0] InvGainSqQ31 = 32'd791897753;

    typedef logic signed [AccWidth-1:0] t_acc;
    typedef logic signed [AngWidth-1:0] t_ang;

    typedef struct packed {
        logic                phase_mode;
        logic                band_enable;
        logic [BinWidth-1:0] band_low;
        logic [BinWidth-1:0] band_high;
    } t_cfg;

    // Arctangent table, pi = 2^22.
    function automatic t_ang atan_of(input logic [4:0] i);
        case (i)
            5'd0:  atan_of = 25'sd1048576;
            5'd1:  atan_of = 25'sd619011;
            5'd2:  atan_of = 25'sd327068;
            5'd3:  atan_of = 25'sd166025;
            5'd4:  atan_of = 25'sd83335;
            5'd5:  atan_of = 25'sd41708;
            5'd6:  atan_of = 25'sd20859;
            5'd7:  atan_of = 25'sd10430;
            5'd8:  atan_of = 25'sd5215;
            5'd9:  atan_of = 25'sd2608;
            5'd10: atan_of = 25'sd1304;
            5'd11: atan_of = 25'sd652;
            5'd12: atan_of = 25'sd326;
            5'd13: atan_of = 25'sd163;
            5'd14: atan_of = 25'sd81;
            5'd15: atan_of = 25'sd41;
            5'd16: atan_of = 25'sd20;
            5'd17: atan_of = 25'sd10;
            5'd18: atan_of = 25'sd5;
            5'd19: atan_of = 25'sd3;
            5'd20: atan_of = 25'sd1;
            default: atan_of = '0;
        endcase
    endfunction

endpackage

[sv/sbpm_cordic_stage.sv]
// One registered CORDIC micro-rotation, usable in vectoring or rotation mode.
// Depends on sbpm_pkg. Carries an opaque side word alongside the vector.
module sbpm_cordic_stage (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_vectoring,
    input  logic [4:0]                      i_step,
    input  logic                            i_valid,
    input  sbpm_pkg::t_acc                  i_x,
    input  sbpm_pkg::t_acc                  i_y,
    input  sbpm_pkg::t_ang                  i_z,
    input  logic [sbpm_pkg::SideWidth-1:0]  i_side,
    output logic                            o_valid,
    output sbpm_pkg::t_acc                  o_x,
    output sbpm_pkg::t_acc                  o_y,
    output sbpm_pkg::t_ang                  o_z,
    output logic [sbpm_pkg::SideWidth-1:0]  o_side
);
    logic           r_valid;
    sbpm_pkg::t_acc r_x, r_y, n_x, n_y;
    sbpm_pkg::t_ang r_z, n_z;
    logic [sbpm_pkg::SideWidth-1:0] r_side;
    logic           w_pos;
    sbpm_pkg::t_acc w_xs, w_ys;
    sbpm_pkg::t_ang w_a;

    // Direction: sign of y when vectoring, sign of residual angle when rotating.
    // Vectoring with y >= 0 and rotating with a negative angle turn the same way.
    always_comb begin
        w_pos = i_vectoring ? (i_y >= 0) : (i_z >= 0);
        w_xs  = i_x >>> i_step;
        w_ys  = i_y >>> i_step;
        w_a   = sbpm_pkg::atan_of(i_step);
        if (w_pos == i_vectoring) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + w_a;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - w_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;
endmodule

[sv/sbpm_cordic.sv]
// Chain of registered CORDIC stages with a shared advance enable.
// Depends on sbpm_pkg and sbpm_cordic_stage.
module sbpm_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_vectoring,
    input  logic                           i_valid,
    input  sbpm_pkg::t_acc                 i_x,
    input  sbpm_pkg::t_acc                 i_y,
    input  sbpm_pkg::t_ang                 i_z,
    input  logic [sbpm_pkg::SideWidth-1:0] i_side,
    output logic                           o_valid,
    output sbpm_pkg::t_acc                 o_x,
    output sbpm_pkg::t_acc                 o_y,
    output sbpm_pkg::t_ang                 o_z,
    output logic [sbpm_pkg::SideWidth-1:0] o_side
);
    localparam int N = sbpm_pkg::CordicSteps;
    logic                           w_v [N+1];
    sbpm_pkg::t_acc                 w_x [N+1];
    sbpm_pkg::t_acc                 w_y [N+1];
    sbpm_pkg::t_ang                 w_z [N+1];
    logic [sbpm_pkg::SideWidth-1:0] w_s [N+1];

    assign w_v[0] = i_valid;
    assign w_x[0] = i_x;
    assign w_y[0] = i_y;
    assign w_z[0] = i_z;
    assign w_s[0] = i_side;

    // One stage per micro-rotation.
    for (genvar g = 0; g < N; g++) begin : g_stage
        sbpm_cordic_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (i_adv),
            .i_vectoring (i_vectoring),
            .i_step      (5'(g)),
            .i_valid     (w_v[g]),
            .i_x         (w_x[g]),
            .i_y         (w_y[g]),
            .i_z         (w_z[g]),
            .i_side      (w_s[g]),
            .o_valid     (w_v[g+1]),
            .o_x         (w_x[g+1]),
            .o_y         (w_y[g+1]),
            .o_z         (w_z[g+1]),
            .o_side      (w_s[g+1])
        );
    end

    assign o_valid = w_v[N];
    assign o_x     = w_x[N];
    assign o_y     = w_y[N];
    assign o_z     = w_z[N];
    assign o_side  = w_s[N];
endmodule

[sv/spectral_bin_phase_modifier.sv]
// Top level of the spectral bin phase modifier: configuration registers,
// band weight, phase blend, two CORDIC pipelines and output rounding.
// Depends on sbpm_pkg and sbpm_cordic.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------------
//   input   | in        | i_valid / o_stall    | i_bin_index, i_bin_real, i_bin_imag
//   output  | out       | o_valid / i_stall    | o_out_real, o_out_imag,
//           |           |                      | o_phase_before, o_phase_after
//   config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One request per cycle is accepted while o_stall is low; the pipeline holds two 21-stage
// CORDIC chains plus input, gain, blend, pre-rotate and output stages.
// The whole pipeline advances when the output register is empty or taken,
// so o_stall follows i_stall only while the output register holds a request.
// Reset is synchronous, active low, and clears the valid bits and configuration registers.
module spectral_bin_phase_modifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sbpm_pkg::BinWidth-1:0] i_bin_index,
    input  logic signed [31:0]           i_bin_real,
    input  logic signed [31:0]           i_bin_imag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [31:0]           o_out_real,
    output logic signed [31:0]           o_out_imag,
    output logic signed [15:0]           o_phase_before,
    output logic signed [15:0]           o_phase_after,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [9:0]                   i_cfg_data
);
    localparam int BW = sbpm_pkg::BinWidth;
    localparam int KW = sbpm_pkg::KWidth;
    localparam int E  = sbpm_pkg::EdgeWidth;
    localparam int SDW = sbpm_pkg::SideWidth;

    sbpm_pkg::t_cfg r_cfg;
    logic           w_adv;
    logic           r_out_valid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_mode  <= 1'b0;
            r_cfg.band_enable <= 1'b0;
            r_cfg.band_low    <= '0;
            r_cfg.band_high   <= BW'(sbpm_pkg::HalfBins);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbpm_pkg::RegPhaseMode: r_cfg.phase_mode  <= i_cfg_data[0];
                sbpm_pkg::RegBandEn:    r_cfg.band_enable <= i_cfg_data[0];
                sbpm_pkg::RegBandLow:   r_cfg.band_low    <= i_cfg_data;
                sbpm_pkg::RegBandHigh:  r_cfg.band_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = !w_adv;

    // Band weight numerator k, 0 .. 2E.
    logic signed [BW+2:0] w_lo, w_hi, w_n;
    logic [KW-1:0]        w_k;
    always_comb begin
        w_lo = (r_cfg.band_low  > BW'(sbpm_pkg::HalfBins)) ? (BW+3)'(sbpm_pkg::HalfBins)
                                                            : (BW+3)'(r_cfg.band_low);
        w_hi = (r_cfg.band_high > BW'(sbpm_pkg::HalfBins)) ? (BW+3)'(sbpm_pkg::HalfBins)
                                                            : (BW+3)'(r_cfg.band_high);
        w_n  = (BW+3)'(i_bin_index);
        w_k  = '0;
        if (w_n >= w_lo && w_n <= w_hi) begin
            w_k = KW'(2 * E);
        end
        if (w_n < w_lo + E && w_n >= w_lo - E) begin
            w_k = KW'(w_n - (w_lo - E));
        end else if (w_n > w_hi - E && w_n <= w_hi + E) begin
            w_k = KW'(w_hi + E - w_n);
        end
        if (!r_cfg.band_enable) begin
            w_k = KW'(2 * E);
        end
    end

    // Stage 0: scale up, quadrant pre-rotation; side carries k, mode, zero flag.
    localparam int SW1 = KW + 2;
    sbpm_pkg::t_acc w_sx, w_sy;
    logic           r0_v;
    sbpm_pkg::t_acc r0_x, r0_y;
    sbpm_pkg::t_ang r0_z;
    logic [SDW-1:0] r0_s;
    always_comb begin
        w_sx = sbpm_pkg::t_acc'(i_bin_real) <<< sbpm_pkg::Guard;
        w_sy = sbpm_pkg::t_acc'(i_bin_imag) <<< sbpm_pkg::Guard;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_adv) begin
            r0_v <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_s <= SDW'({w_k, r_cfg.phase_mode, (i_bin_real == 0 && i_bin_imag == 0)});
            if (w_sx < 0 && w_sy >= 0) begin
                r0_x <= w_sy; r0_y <= -w_sx; r0_z <= sbpm_pkg::AngHalfPi;
            end else if (w_sx < 0) begin
                r0_x <= -w_sy; r0_y <= w_sx; r0_z <= -sbpm_pkg::AngHalfPi;
            end else begin
                r0_x <= w_sx; r0_y <= w_sy; r0_z <= '0;
            end
        end
    end

    logic           v1_v;
    sbpm_pkg::t_acc v1_x, v1_y;
    sbpm_pkg::t_ang v1_z;
    logic [SDW-1:0] v1_s;
    sbpm_cordic u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vectoring(1'b1),
        .i_valid(r0_v), .i_x(r0_x), .i_y(r0_y), .i_z(r0_z), .i_side(r0_s),
        .o_valid(v1_v), .o_x(v1_x), .o_y(v1_y), .o_z(v1_z), .o_side(v1_s)
    );

    // Stage A: gain partial products and pre phase.
    logic [31:0]    w_mx_hi, w_mx_lo;
    logic signed [15:0] w_pre;
    sbpm_pkg::t_ang w_zr;
    logic           ra_v;
    logic [63:0]    ra_phi, ra_plo;
    logic signed [15:0] ra_pre;
    logic [SW1-1:0] ra_s;
    always_comb begin
        w_mx_hi = (v1_x < 0) ? '0 : v1_x[63:32];
        w_mx_lo = (v1_x < 0) ? '0 : v1_x[31:0];
        w_zr    = v1_s[0] ? '0 : v1_z;
        w_pre   = 16'((w_zr + 25'sd64) >>> 7);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
        end else if (w_adv) begin
            ra_v <= v1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            ra_phi <= 64'(w_mx_hi) * 64'(sbpm_pkg::InvGainSqQ31);
            ra_plo <= 64'(w_mx_lo) * 64'(sbpm_pkg::InvGainSqQ31);
            ra_pre <= v1_s[0] ? '0 : w_pre;
            ra_s   <= v1_s[SW1-1:0];
        end
    end

    // Stage B: magnitude sum and phase product pre * f.
    logic signed [KW+1:0] w_f;
    logic           rb_v;
    logic [63:0]    rb_mag;
    logic signed [23:0] rb_prod;
    logic signed [15:0] rb_pre;
    always_comb begin
        w_f = (KW+2)'(2 * E) - ((KW+2)'(ra_s[SW1-1:2]) <<< (ra_s[1] ? 1 : 0));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_v <= 1'b0;
        end else if (w_adv) begin
            rb_v <= ra_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rb_mag  <= (ra_phi << 1) + (ra_plo >> 31);
            rb_prod <= 24'(ra_pre) * 24'(w_f);
            rb_pre  <= ra_pre;
        end
    end

    // Stage C: rounded divide by 2E, wrap, quadrant setup.
    // The divide is a multiply by ceil(2^21 / 2E) and a shift; it is exact
    // because |pre * f| + E stays below 2^18.
    localparam int DivShift = 21;
    localparam logic [19:0] RecipTwoE = 20'((2**DivShift + 2 * E - 1) / (2 * E));
    logic [23:0]    w_abs, w_q;
    logic [47:0]    w_qp;
    logic signed [15:0] w_post;
    sbpm_pkg::t_ang w_t;
    sbpm_pkg::t_acc w_mag;
    logic           rc_v;
    sbpm_pkg::t_acc rc_x, rc_y;
    sbpm_pkg::t_ang rc_t;
    logic [31:0]    rc_side;
    always_comb begin
        w_abs  = rb_prod < 0 ? 24'(-rb_prod) : 24'(rb_prod);
        w_qp   = 48'(w_abs + 24'(E)) * 48'(RecipTwoE);
        w_q    = w_qp[DivShift+23:DivShift];
        w_post = rb_prod < 0 ? 16'(-w_q) : 16'(w_q);
        w_t    = sbpm_pkg::t_ang'(w_post) <<< 7;
        w_mag  = sbpm_pkg::t_acc'(rb_mag);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_v <= 1'b0;
        end else if (w_adv) begin
            rc_v <= rb_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rc_side <= {rb_pre, w_post};
            if (w_t > sbpm_pkg::AngHalfPi) begin
                rc_x <= '0; rc_y <= w_mag; rc_t <= w_t - sbpm_pkg::AngHalfPi;
            end else if (w_t < -sbpm_pkg::AngHalfPi) begin
                rc_x <= '0; rc_y <= -w_mag; rc_t <= w_t + sbpm_pkg::AngHalfPi;
            end else begin
                rc_x <= w_mag; rc_y <= '0; rc_t <= w_t;
            end
        end
    end

    logic           v2_v;
    sbpm_pkg::t_acc v2_x, v2_y;
    sbpm_pkg::t_ang v2_z;
    logic [31:0]    v2_s;
    sbpm_cordic u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vectoring(1'b0),
        .i_valid(rc_v), .i_x(rc_x), .i_y(rc_y), .i_z(rc_t), .i_side(rc_side),
        .o_valid(v2_v), .o_x(v2_x), .o_y(v2_y), .o_z(v2_z), .o_side(v2_s)
    );

    // Output stage: round, saturate and register.
    sbpm_pkg::t_acc w_rx, w_ry;
    logic signed [31:0] w_ox, w_oy, r_ox, r_oy;
    logic [31:0] r_ph;
    localparam sbpm_pkg::t_acc SatMax = 64'sd2147483647;
    localparam sbpm_pkg::t_acc SatMin = -64'sd2147483648;
    always_comb begin
        w_rx = (v2_x + (64'sd1 <<< (sbpm_pkg::Guard - 1))) >>> sbpm_pkg::Guard;
        w_ry = (v2_y + (64'sd1 <<< (sbpm_pkg::Guard - 1))) >>> sbpm_pkg::Guard;
        w_ox = w_rx > SatMax ? 32'sh7FFFFFFF : (w_rx < SatMin ? 32'sh80000000 : 32'(w_rx));
        w_oy = w_ry > SatMax ? 32'sh7FFFFFFF : (w_ry < SatMin ? 32'sh80000000 : 32'(w_ry));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= v2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv && v2_z == v2_z) begin
            r_ox <= w_ox;
            r_oy <= w_oy;
            r_ph <= v2_s;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_real     = r_ox;
    assign o_out_imag     = r_oy;
    assign o_phase_before = r_ph[31:16];
    assign o_phase_after  = r_ph[15:0];
endmodule

[sv/sbpm_checker.sv]
// Port-level checker for the spectral bin phase modifier, bound to the top.
// Depends only on the top level's ports.
module sbpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_real,
    input logic [15:0] o_phase_before
);
    // A held output request keeps its real part and its phase before.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_real) && $stable(o_phase_before))
        else $error("output payload changed while stalled");

    // The input stalls only while an output request is held.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without downstream back-pressure");

    // Nothing valid right after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind spectral_bin_phase_modifier sbpm_checker u_sbpm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_out_real(o_out_real),
    .o_phase_before(o_phase_before)
);

[bench/spectral_bin_phase_modifier_test.sv]
// Self-checking testbench for spectral_bin_phase_modifier: directed and random
// bins under several band settings, with a bit-exact CORDIC predictor.
// Depends on sbpm_pkg and the RTL in sv/.
`timescale 1ns / 1ps

module spectral_bin_phase_modifier_test;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic signed [15:0] ph_pre;
        logic signed [15:0] ph_post;
    } t_bin_result;

    // Holds the register copy and the queue of rebuilt bins still to come.
    class t_bin_scoreboard;
        t_bin_result pending[$];
        logic        mode;
        logic        band_on;
        int          low_bin;
        int          high_bin;
        int          errors;
        int          checked;

        function new();
            mode = 0;
            band_on = 0;
            low_bin = 0;
            high_bin = 512;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [9:0] data);
            case (idx)
                sbpm_pkg::RegPhaseMode: mode = data[0];
                sbpm_pkg::RegBandEn:    band_on = data[0];
                sbpm_pkg::RegBandLow:   low_bin = int'(data);
                sbpm_pkg::RegBandHigh:  high_bin = int'(data);
                default: ;
            endcase
        endfunction

        // Blend weight numerator out of 2*EdgeWidth.
        function int weight(input int n);
            int lo;
            int hi;
            int k;
            lo = low_bin;
            hi = high_bin;
            k = 0;
            if (!band_on) return 2 * sbpm_pkg::EdgeWidth;
            if (lo > sbpm_pkg::HalfBins) lo = sbpm_pkg::HalfBins;
            if (hi > sbpm_pkg::HalfBins) hi = sbpm_pkg::HalfBins;
            if (n >= lo && n <= hi) k = 2 * sbpm_pkg::EdgeWidth;
            if (n < lo + sbpm_pkg::EdgeWidth && n >= lo - sbpm_pkg::EdgeWidth)
                k = n - (lo - sbpm_pkg::EdgeWidth);
            else if (n > hi - sbpm_pkg::EdgeWidth && n <= hi + sbpm_pkg::EdgeWidth)
                k = hi + sbpm_pkg::EdgeWidth - n;
            return k;
        endfunction

        function t_bin_result rotate_bin(input logic [9:0] idx,
                                         input logic signed [31:0] re_in,
                                         input logic signed [31:0] im_in);
            t_bin_result r;
            longint x;
            longint y;
            longint z;
            longint t;
            longint xn;
            longint yn;
            longint f;
            longint a;
            longint q;
            longint unsigned mag;
            longint unsigned m;
            logic signed [15:0] pre;
            logic signed [15:0] post;
            longint tmp;
            x = longint'(re_in) <<< sbpm_pkg::Guard;
            y = longint'(im_in) <<< sbpm_pkg::Guard;
            z = 0;
            mag = 0;
            // Vectoring pass: magnitude and angle.
            if (x != 0 || y != 0) begin
                if (x < 0) begin
                    if (y >= 0) begin
                        xn = y; yn = -x; z = sbpm_pkg::AngHalfPi;
                    end else begin
                        xn = -y; yn = x; z = -sbpm_pkg::AngHalfPi;
                    end
                    x = xn; y = yn;
                end
                for (int i = 0; i < sbpm_pkg::CordicSteps; i++) begin
                    if (y >= 0) begin
                        xn = x + (y >>> i); yn = y - (x >>> i);
                        z += sbpm_pkg::atan_of(5'(i));
                    end else begin
                        xn = x - (y >>> i); yn = y + (x >>> i);
                        z -= sbpm_pkg::atan_of(5'(i));
                    end
                    x = xn; y = yn;
                end
                m = (x < 0) ? 0 : longint'(x);
                mag = (((m >> 32) * sbpm_pkg::InvGainSqQ31) << 1) +
                      (((m & 64'hFFFF_FFFF) * sbpm_pkg::InvGainSqQ31) >> 31);
            end
            tmp = (z + 64) >>> 7;
            pre = tmp[15:0];
            // Blend the phase toward zero or its negation.
            f = 2 * sbpm_pkg::EdgeWidth - longint'(weight(idx)) * (mode ? 2 : 1);
            a = longint'(pre) * f;
            q = ((a < 0 ? -a : a) + sbpm_pkg::EdgeWidth) / (2 * sbpm_pkg::EdgeWidth);
            if (a < 0) q = -q;
            post = q[15:0];
            // Rotation pass: rebuild from the unchanged magnitude.
            t = longint'(post) * 128;
            x = mag;
            y = 0;
            if (t > sbpm_pkg::AngHalfPi) begin
                x = 0; y = mag; t -= sbpm_pkg::AngHalfPi;
            end else if (t < -sbpm_pkg::AngHalfPi) begin
                x = 0; y = -longint'(mag); t += sbpm_pkg::AngHalfPi;
            end
            for (int i = 0; i < sbpm_pkg::CordicSteps; i++) begin
                if (t >= 0) begin
                    xn = x - (y >>> i); yn = y + (x >>> i);
                    t -= sbpm_pkg::atan_of(5'(i));
                end else begin
                    xn = x + (y >>> i); yn = y - (x >>> i);
                    t += sbpm_pkg::atan_of(5'(i));
                end
                x = xn; y = yn;
            end
            x = (x + (longint'(1) <<< (sbpm_pkg::Guard - 1))) >>> sbpm_pkg::Guard;
            y = (y + (longint'(1) <<< (sbpm_pkg::Guard - 1))) >>> sbpm_pkg::Guard;
            if (x > 64'sd2147483647) x = 64'sd2147483647;
            if (x < -64'sd2147483648) x = -64'sd2147483648;
            if (y > 64'sd2147483647) y = 64'sd2147483647;
            if (y < -64'sd2147483648) y = -64'sd2147483648;
            r.re = x[31:0];
            r.im = y[31:0];
            r.ph_pre = pre;
            r.ph_post = post;
            return r;
        endfunction

        function void note_request(input logic [9:0] idx, input logic signed [31:0] re,
                                   input logic signed [31:0] im);
            pending = {pending, rotate_bin(idx, re, im)};
        endfunction

        function void check_result(input t_bin_result got);
            t_bin_result exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result re=%0d im=%0d", $time, got.re, got.im);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.re !== exp.re) begin
                $display("%0t: out_real exp %0d got %0d", $time, exp.re, got.re);
                errors++;
            end
            if (got.im !== exp.im) begin
                $display("%0t: out_imag exp %0d got %0d", $time, exp.im, got.im);
                errors++;
            end
            if (got.ph_pre !== exp.ph_pre) begin
                $display("%0t: phase_before exp %0d got %0d", $time, exp.ph_pre, got.ph_pre);
                errors++;
            end
            if (got.ph_post !== exp.ph_post) begin
                $display("%0t: phase_after exp %0d got %0d", $time, exp.ph_post, got.ph_post);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic [9:0]         i_bin_index = '0;
    logic signed [31:0] i_bin_real = '0;
    logic signed [31:0] i_bin_imag = '0;
    logic               o_valid;
    logic               i_stall = 0;
    logic signed [31:0] o_out_real;
    logic signed [31:0] o_out_imag;
    logic signed [15:0] o_phase_before;
    logic signed [15:0] o_phase_after;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_index = '0;
    logic [9:0]         i_cfg_data = '0;

    t_bin_scoreboard board = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  quiet_cycles = 0;
    int  sent = 0;

    spectral_bin_phase_modifier DUT (.*);

    always #5 i_clk = ~i_clk;

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Result monitor and idle watchdog.
    always @(posedge i_clk) begin
        t_bin_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.re = o_out_real;
            got.im = o_out_imag;
            got.ph_pre = o_phase_before;
            got.ph_post = o_phase_after;
            board.check_result(got);
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Watchdog expired with %0d results pending", board.pending.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one request, with an optional idle gap first, and wait for it.
    task automatic send_bin(input logic [9:0] idx, input logic signed [31:0] re,
                            input logic signed [31:0] im);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_bin_index <= idx;
        i_bin_real <= re;
        i_bin_imag <= im;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_request(idx, re, im);
        sent++;
    endtask

    // Drop valid and hold off until every expected result has arrived.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Write all four registers while the pipeline is empty.
    task automatic set_regs(input logic mode, input logic band_on, input int lo,
                            input int hi);
        logic [9:0] vals[4];
        vals[0] = 10'(mode);
        vals[1] = 10'(band_on);
        vals[2] = 10'(lo);
        vals[3] = 10'(hi);
        drain();
        for (int r = 0; r < 4; r++) begin
            i_cfg_we <= 1;
            i_cfg_index <= 2'(r);
            i_cfg_data <= vals[r];
            board.write_reg(2'(r), vals[r]);
            @(negedge i_clk);
        end
        i_cfg_we <= 0;
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 0;
            3: return $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // Bins cluster around the band edges so the soft ramps see most traffic.
    function automatic logic [9:0] rand_bin();
        int c;
        case ($urandom_range(3))
            0: return 10'($urandom_range(1023));
            1: c = board.low_bin;
            2: c = board.high_bin;
            default: c = sbpm_pkg::HalfBins;
        endcase
        c = c + $signed($urandom_range(10)) - 5;
        if (c < 0) c = 0;
        return c[9:0];
    endfunction

    initial begin
        int lows[6];
        int highs[6];
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: zero bin, axes, extremes and a phase of exactly pi.
        send_bin(0, 0, 0);
        send_bin(512, 32'sh7FFF_FFFF, 0);
        send_bin(1023, 32'sh8000_0000, 0);
        send_bin(5, 0, 32'sh7FFF_FFFF);
        send_bin(6, 0, 32'sh8000_0000);
        send_bin(7, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_bin(8, 32'sh8000_0000, 32'sh8000_0000);
        send_bin(9, -1, 1);
        set_regs(1, 0, 0, 512);
        send_bin(0, 32'sh8000_0000, 0);
        send_bin(1, 32'sh8000_0000, -1);
        send_bin(2, 1000, -700);
        send_bin(3, 0, 0);
        set_regs(1, 1, 10, 20);
        for (int n = 6; n <= 24; n += 3)
            send_bin(10'(n), -123456789, 987654321);

        // Random phases across band settings, including the register extremes.
        lows = '{100, 0, 300, 1023, 3, 512};
        highs = '{200, 512, 50, 1023, 509, 0};
        for (int p = 0; p < 6; p++) begin
            set_regs(p[0], (p != 0), lows[p], highs[p]);
            for (int n = 0; n < 160; n++) begin
                if (n < 53) begin
                    tx_idle_pct = 15; rx_stall_pct = 80;
                end else if (n < 106) begin
                    tx_idle_pct = 80; rx_stall_pct = 15;
                end else begin
                    tx_idle_pct = 0; rx_stall_pct = 0;
                end
                send_bin(rand_bin(), rand_sample(), rand_sample());
            end
        end
        drain();

        $display("Sent %0d bins over six band settings and both phase modes; %0d checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
